/* hdl/hmpd_pkg.sv */
// Shared types, codes and constants of the hold-and-modify palette decoder.
// No dependencies; imported by every module of the block.
package hmpd_pkg;

	localparam int DEF_PALETTE_ENTRIES = 256;
	localparam int DEF_MAX_LINE_PITCH  = 4096;
	localparam int MAX_LINES           = 4096;

	localparam int INDEX_W = 8;
	localparam int LEVEL_W = 8;
	localparam int COLOR_W = 24;
	localparam int DEPTH_W = 4;
	localparam int PITCH_W = 13;
	localparam int LINES_W = 13;
	localparam int LINE_CNT_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_DEPTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HAM_ENABLE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_FRAME = 2'd3;

	localparam logic [DEPTH_W-1:0] RST_PLANE_DEPTH     = 4'd6;
	localparam logic               RST_HAM_ENABLE      = 1'b0;
	localparam logic [PITCH_W-1:0] RST_LINE_PITCH      = 13'd320;
	localparam logic [LINES_W-1:0] RST_LINES_PER_FRAME = 13'd256;

	// Input item kinds (carried on tuser).
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// Hold-and-modify control codes (top two depth bits).
	localparam logic [1:0] HAM_LOOKUP = 2'd0;
	localparam logic [1:0] HAM_BLUE   = 2'd1;
	localparam logic [1:0] HAM_RED    = 2'd2;
	localparam logic [1:0] HAM_GREEN  = 2'd3;

	typedef enum logic [1:0] {
		KIND_LOOKUP,
		KIND_BLUE,
		KIND_RED,
		KIND_GREEN
	} pix_kind_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] plane_depth;
		logic               ham_enable;
		logic [PITCH_W-1:0] line_pitch;
		logic [LINES_W-1:0] lines_per_frame;
	} cfg_t;

	typedef struct packed {
		pix_kind_t          kind;
		logic [LEVEL_W-1:0] level;
		logic               first;
		logic               eol;
		logic               eof;
	} pix_ctrl_t;

endpackage

/* hdl/hold_modify_palette_decoder_top.sv */
// Top level of the hold-and-modify palette decoder: channels and stage wiring.
// Depends on hmpd_pkg, hmpd_cfg, hmpd_front, hmpd_palette, hmpd_out.
//
//  Channel | Signals                              | Direction | Item
//  --------+--------------------------------------+-----------+-------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser     | in        | palette write or pixel index
//  m_      | m_tvalid m_tready m_tdata m_tlast ... | out       | RGB color with line/frame ends
//  cfg_    | cfg_valid cfg_ready cfg_index ...     | in        | register write
//
// One item per clock sustained while m_tready is high. An accepted pixel has
// its palette read and controls registered, its color formed from them, and the
// color registered into the output stage on m_. Palette writes give no result.
// Reset clears the counters, held color and valid bits and loads the config
// registers with their defaults; the palette is not cleared. A stall on m_tready
// fills the color stage and then drops s_tready; the previous-color loop closes
// within the color stage, so stalls never disturb the hold-modify chain.
module hold_modify_palette_decoder_top #(
	parameter int PALETTE_ENTRIES = hmpd_pkg::DEF_PALETTE_ENTRIES,
	parameter int MAX_LINE_PITCH  = hmpd_pkg::DEF_MAX_LINE_PITCH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [31:0]                     s_tdata,   // index_value, entry_red, entry_green, entry_blue
	input  logic                            s_tuser,   // command
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hmpd_pkg::COLOR_W-1:0]    m_tdata,   // out_red, out_green, out_blue
	output logic                            m_tlast,   // end_of_line
	output logic                            m_tuser,   // end_of_frame
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hmpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hmpd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hmpd_pkg::*;

	cfg_t               cfg;
	pix_ctrl_t          ctrl;
	logic               take;
	logic               take_pix;
	logic               take_wr;
	logic [INDEX_W-1:0] index_value;
	logic [COLOR_W-1:0] wr_color;
	logic [INDEX_W-1:0] rd_addr;
	logic [COLOR_W-1:0] rd_data;
	logic [COLOR_W-1:0] entry0;

	// Unpack the input item: index, then red, green, blue from the low bits up.
	assign index_value = s_tdata[7:0];
	assign wr_color    = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};

	assign take     = s_tvalid && s_tready;
	assign take_pix = take && (s_tuser == CMD_PIXEL);
	assign take_wr  = take && (s_tuser == CMD_WRITE);

	hmpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hmpd_front #(
		.MAX_LINE_PITCH (MAX_LINE_PITCH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.take_pix    (take_pix),
		.index_value (index_value),
		.rd_addr     (rd_addr),
		.ctrl        (ctrl)
	);

	hmpd_palette #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_palette (
		.clk      (clk),
		.wr_en    (take_wr),
		.wr_idx   (index_value),
		.wr_color (wr_color),
		.rd_en    (take_pix),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.entry0   (entry0)
	);

	hmpd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.take_pix (take_pix),
		.ctrl     (ctrl),
		.entry0   (entry0),
		.rd_data  (rd_data),
		.in_ready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

/* hdl/hmpd_cfg.sv */
// Configuration register file of the hold-and-modify palette decoder.
// Depends on hmpd_pkg.
module hmpd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hmpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hmpd_pkg::CFG_DATA_W-1:0] cfg_data,
	output hmpd_pkg::cfg_t                 cfg
);
	import hmpd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plane_depth     <= RST_PLANE_DEPTH;
			cfg_q.ham_enable      <= RST_HAM_ENABLE;
			cfg_q.line_pitch      <= RST_LINE_PITCH;
			cfg_q.lines_per_frame <= RST_LINES_PER_FRAME;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PLANE_DEPTH:     cfg_q.plane_depth     <= cfg_data[DEPTH_W-1:0];
				CFG_HAM_ENABLE:      cfg_q.ham_enable      <= cfg_data[0];
				CFG_LINE_PITCH:      cfg_q.line_pitch      <= cfg_data[PITCH_W-1:0];
				CFG_LINES_PER_FRAME: cfg_q.lines_per_frame <= cfg_data[LINES_W-1:0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

endmodule

/* hdl/hmpd_front.sv */
// Pixel decode front end: depth masking, hold-modify split, line/frame counters.
// Depends on hmpd_pkg.
module hmpd_front #(
	parameter int MAX_LINE_PITCH = hmpd_pkg::DEF_MAX_LINE_PITCH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hmpd_pkg::cfg_t               cfg,
	input  logic                         take_pix,
	input  logic [hmpd_pkg::INDEX_W-1:0] index_value,
	output logic [hmpd_pkg::INDEX_W-1:0] rd_addr,
	output hmpd_pkg::pix_ctrl_t          ctrl
);
	import hmpd_pkg::*;

	localparam int CW   = $clog2(MAX_LINE_PITCH);
	localparam int MAXW = $clog2(MAX_LINE_PITCH + 1);
	localparam int PW   = (MAXW > PITCH_W) ? MAXW : PITCH_W;

	logic [INDEX_W-1:0]    pix;
	logic [INDEX_W-1:0]    data;
	logic [1:0]            mode;
	logic [LEVEL_W-1:0]    level;
	logic [CW-1:0]         col_q;
	logic [LINE_CNT_W-1:0] line_q;
	logic [PW-1:0]         pitch_c;
	logic [PW-1:0]         col_lim;
	logic [LINES_W-1:0]    lines_c;
	logic [LINES_W-1:0]    line_lim;
	logic                  eol;
	logic                  eof;

	// Split the pixel by depth: mask, top two bits, data bits moved to the top of a byte.
	always_comb begin
		unique case (cfg.plane_depth)
			4'd0, 4'd1, 4'd2, 4'd3: begin
				pix = {5'b0, index_value[2:0]}; mode = index_value[2:1];
				data = {7'b0, index_value[0]}; level = {index_value[0], 7'b0};
			end
			4'd4: begin
				pix = {4'b0, index_value[3:0]}; mode = index_value[3:2];
				data = {6'b0, index_value[1:0]}; level = {index_value[1:0], 6'b0};
			end
			4'd5: begin
				pix = {3'b0, index_value[4:0]}; mode = index_value[4:3];
				data = {5'b0, index_value[2:0]}; level = {index_value[2:0], 5'b0};
			end
			4'd6: begin
				pix = {2'b0, index_value[5:0]}; mode = index_value[5:4];
				data = {4'b0, index_value[3:0]}; level = {index_value[3:0], 4'b0};
			end
			4'd7: begin
				pix = {1'b0, index_value[6:0]}; mode = index_value[6:5];
				data = {3'b0, index_value[4:0]}; level = {index_value[4:0], 3'b0};
			end
			default: begin
				pix = index_value; mode = index_value[7:6];
				data = {2'b0, index_value[5:0]}; level = {index_value[5:0], 2'b0};
			end
		endcase
	end

	always_comb begin
		rd_addr    = pix;
		ctrl.kind  = KIND_LOOKUP;
		ctrl.level = level;
		ctrl.first = (col_q == '0);
		ctrl.eol   = eol;
		ctrl.eof   = eof;
		if (cfg.ham_enable) begin
			unique case (mode)
				HAM_LOOKUP: begin
					ctrl.kind = KIND_LOOKUP;
					rd_addr   = data;
				end
				HAM_BLUE:  ctrl.kind = KIND_BLUE;
				HAM_RED:   ctrl.kind = KIND_RED;
				HAM_GREEN: ctrl.kind = KIND_GREEN;
				default:   ctrl.kind = KIND_LOOKUP;
			endcase
		end
	end

	// Clamp the limits and find the line and frame ends.
	always_comb begin
		pitch_c = PW'(cfg.line_pitch);
		if (pitch_c == '0) begin
			pitch_c = PW'(1);
		end else if (pitch_c > PW'(MAX_LINE_PITCH)) begin
			pitch_c = PW'(MAX_LINE_PITCH);
		end
		col_lim = pitch_c - PW'(1);

		lines_c = cfg.lines_per_frame;
		if (lines_c == '0) begin
			lines_c = LINES_W'(1);
		end else if (lines_c > LINES_W'(MAX_LINES)) begin
			lines_c = LINES_W'(MAX_LINES);
		end
		line_lim = lines_c - LINES_W'(1);

		eol = (PW'(col_q) >= col_lim);
		eof = eol && (LINES_W'(line_q) >= line_lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
		end else if (take_pix) begin
			if (eol) begin
				col_q  <= '0;
				line_q <= eof ? '0 : line_q + LINE_CNT_W'(1);
			end else begin
				col_q  <= col_q + CW'(1);
			end
		end
	end

endmodule

/* hdl/hmpd_palette.sv */
// Palette memory with registered read and a copy of entry 0 for line starts.
// Depends on hmpd_pkg.
module hmpd_palette #(
	parameter int PALETTE_ENTRIES = hmpd_pkg::DEF_PALETTE_ENTRIES
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [hmpd_pkg::INDEX_W-1:0] wr_idx,
	input  logic [hmpd_pkg::COLOR_W-1:0] wr_color,
	input  logic                         rd_en,
	input  logic [hmpd_pkg::INDEX_W-1:0] rd_addr,
	output logic [hmpd_pkg::COLOR_W-1:0] rd_data,
	output logic [hmpd_pkg::COLOR_W-1:0] entry0
);
	import hmpd_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	logic [COLOR_W-1:0] mem [PALETTE_ENTRIES];
	logic [COLOR_W-1:0] rd_data_q;
	logic [COLOR_W-1:0] entry0_q;
	logic               wr_in_range;
	logic               rd_in_range;

	assign wr_in_range = ({1'b0, wr_idx} < (INDEX_W + 1)'(PALETTE_ENTRIES));
	assign rd_in_range = ({1'b0, rd_addr} < (INDEX_W + 1)'(PALETTE_ENTRIES));

	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			mem[wr_idx[AW-1:0]] <= wr_color;
		end
		if (rd_en) begin
			rd_data_q <= rd_in_range ? mem[rd_addr[AW-1:0]] : '0;
		end
	end

	// Keep entry 0 in flops: it seeds the previous color at every line start.
	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == '0) begin
			entry0_q <= wr_color;
		end
	end

	assign rd_data = rd_data_q;
	assign entry0  = entry0_q;

endmodule

/* hdl/hmpd_out.sv */
// Color stage and output register: merges palette data with the held color.
// Depends on hmpd_pkg.
module hmpd_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take_pix,
	input  hmpd_pkg::pix_ctrl_t          ctrl,
	input  logic [hmpd_pkg::COLOR_W-1:0] entry0,
	input  logic [hmpd_pkg::COLOR_W-1:0] rd_data,
	output logic                         in_ready,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [hmpd_pkg::COLOR_W-1:0] m_tdata,  // out_red, out_green, out_blue
	output logic                         m_tlast,  // end_of_line
	output logic                         m_tuser   // end_of_frame
);
	import hmpd_pkg::*;

	logic               v_s1;
	pix_ctrl_t          ctrl_s1;
	logic [COLOR_W-1:0] entry0_s1;
	logic               v_s2;
	logic [COLOR_W-1:0] color_s2;  // {red, green, blue}
	logic               eol_s2;
	logic               eof_s2;
	logic [COLOR_W-1:0] prev_q;
	logic [COLOR_W-1:0] prev;
	logic [COLOR_W-1:0] color;
	logic               adv;

	assign adv      = v_s1 && (!v_s2 || m_tready);
	assign in_ready = !v_s1 || adv;

	always_comb begin
		prev = ctrl_s1.first ? entry0_s1 : prev_q;
		unique case (ctrl_s1.kind)
			KIND_LOOKUP: color = rd_data;
			KIND_BLUE:   color = {prev[23:8], ctrl_s1.level};
			KIND_RED:    color = {ctrl_s1.level, prev[15:0]};
			KIND_GREEN:  color = {prev[23:16], ctrl_s1.level, prev[7:0]};
			default:     color = rd_data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			prev_q <= '0;
		end else begin
			if (take_pix) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2   <= 1'b1;
				prev_q <= color;
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_pix) begin
			ctrl_s1   <= ctrl;
			entry0_s1 <= entry0;
		end
		if (adv) begin
			color_s2 <= color;
			eol_s2   <= ctrl_s1.eol;
			eof_s2   <= ctrl_s1.eof;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {color_s2[7:0], color_s2[15:8], color_s2[23:16]};
	assign m_tlast  = eol_s2;
	assign m_tuser  = eof_s2;

	a_eof_has_eol: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && eof_s2 |-> eol_s2)
		else $error("frame end without line end");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		take_pix |-> (!v_s1 || adv))
		else $error("pixel taken while color stage is blocked");

	a_prev_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> prev_q == color_s2)
		else $error("held color differs from last delivered color");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1)
		else $error("stalled pixel lost from color stage");

endmodule
